@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by pms_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, widths and constants of the PID motor speed PWM controller.
// ----------------------------------------------------------------------------
package pms_pkg;

	// field widths
	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = SPEED_W + 1;
	localparam int DERR_W  = ERR_W + 1;
	localparam int SUM_W   = 32;
	localparam int PWM_W   = 9;
	localparam int FRAC_W  = 8;

	// product and accumulator widths
	localparam int P_ERR_W  = ERR_W + GAIN_W;
	localparam int P_DERR_W = DERR_W + GAIN_W;
	localparam int P_SUM_W  = SUM_W + GAIN_W;
	localparam int PID_W    = P_SUM_W + 2;
	localparam int PM_W     = PWM_W + SPEED_W;
	localparam int QX_W     = SPEED_W + 1;

	// integral saturation limits
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// largest PWM magnitude
	localparam logic [PWM_W-2:0] PWM_MAG_MAX = {(PWM_W-1){1'b1}};

	// register reset values
	localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 16'sd128;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = 16'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = 16'sd0;
	localparam logic [SPEED_W-1:0]       MAX_SPEED_RST = 16'd100;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_GAIN_P    = 2'd0,
		REG_GAIN_I    = 2'd1,
		REG_GAIN_D    = 2'd2,
		REG_MAX_SPEED = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] target_speed;
		logic signed [SPEED_W-1:0] measured_speed;
	} in_item_t;

	typedef struct packed {
		logic signed [PWM_W-1:0] pwm_out;
	} out_item_t;

	typedef struct packed {
		reg_idx_t          index;
		logic [GAIN_W-1:0] value;
	} cfg_item_t;

endpackage

@@ hdl/pms_stream_if.sv @@
// ----------------------------------------------------------------------------
// pms_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/pms_serial_mul.sv @@
// ----------------------------------------------------------------------------
// pms_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, optional signed
// multiplier (top bit weighted negative).
// ----------------------------------------------------------------------------
module pms_serial_mul #(
	parameter int A_W      = 16,
	parameter int B_W      = 16,
	parameter int P_W      = 32,
	parameter bit B_SIGNED = 1'b1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [A_W-1:0] mcand,
	input  logic [B_W-1:0]        mplier,
	output logic                  busy,
	output logic signed [P_W-1:0] product
);

	localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [P_W-1:0] acc_q;
	logic signed [P_W-1:0] mcand_q;
	logic [B_W-1:0]        mplier_q;
	logic                  last;
	logic signed [P_W-1:0] acc_next;

	assign last = (cnt_q == LAST);

	// add the shifted multiplicand for a set bit, subtract for a signed top bit
	always_comb begin
		acc_next = acc_q;
		if (mplier_q[0]) begin
			if (B_SIGNED && last) begin
				acc_next = acc_q - mcand_q;
			end else begin
				acc_next = acc_q + mcand_q;
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operand shifters and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= P_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

@@ hdl/pms_serial_div.sv @@
// ----------------------------------------------------------------------------
// pms_serial_div
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2**Q_W, so only Q_W steps are needed.
// ----------------------------------------------------------------------------
module pms_serial_div #(
	parameter int Q_W = 8,
	parameter int D_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [D_W+Q_W-1:0] dividend,
	input  logic [D_W-1:0]     divisor,
	output logic               busy,
	output logic [Q_W-1:0]     quotient
);

	localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [D_W:0]     part;
	logic [D_W:0]     trial;
	logic             fits;
	logic [Q_W:0]     quo_next;

	// next partial remainder: bring down one dividend bit, try a subtract
	assign part     = {rem_q, quo_q[Q_W-1]};
	assign trial    = part - {1'b0, divisor};
	assign fits     = (part >= {1'b0, divisor});
	assign quo_next = {quo_q, fits};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[Q_W +: D_W];
			quo_q <= dividend[Q_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? trial[D_W-1:0] : part[D_W-1:0];
			quo_q <= quo_next[Q_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ hdl/pid_motor_speed_pwm.sv @@
// ----------------------------------------------------------------------------
// pid_motor_speed_pwm
// Positional PID speed controller producing a signed PWM duty value.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one transaction per control tick (target and measured rpm).
//   result : one transaction per tick, the new signed PWM duty.
//   cfg    : register writes (gains in Q8.8, max_speed); always ready,
//            write only while no tick is in flight.
// Sequence (FS_W = bits of PWM_FULL_SCALE, 8 for the default):
//   each sample goes through two 16-step bit-serial multiply passes
//   (gains, then full-scale/max_speed scaling) and an FS_W-step divider;
//   the next sample is taken only once the result has been loaded into
//   the output register.
// Reset: gains 0.5/0/0, max_speed 100, integral, last error and last PWM
//   cleared; ready for a sample right after reset.
// Stall: the result sits in an output register, so the next sample is
//   accepted while it waits; a second finished result waits in the divider
//   stage until the register frees up.
// ----------------------------------------------------------------------------
module pid_motor_speed_pwm #(
	parameter int PWM_FULL_SCALE = 255
) (
	input logic         clk,
	input logic         arst_n,
	pms_stream_if.sink  cfg,
	pms_stream_if.sink  sample,
	pms_stream_if.source result
);

	localparam int FS_W   = $clog2(PWM_FULL_SCALE + 1);
	localparam int S_W    = pms_pkg::PID_W + FS_W + 1;
	localparam int LIM_W  = pms_pkg::SPEED_W + 1 + FS_W;
	localparam int DV_W   = pms_pkg::SPEED_W + FS_W;
	localparam logic [FS_W-1:0] FS_VAL = FS_W'(PWM_FULL_SCALE);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOAD1 = 8'b0000_0010,
		ST_MUL1  = 8'b0000_0100,
		ST_ADD   = 8'b0000_1000,
		ST_MUL2  = 8'b0001_0000,
		ST_CLAMP = 8'b0010_0000,
		ST_SAT   = 8'b0100_0000,
		ST_DIV   = 8'b1000_0000
	} state_t;

	state_t state_q, state_next;

	// configuration registers
	logic signed [pms_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [pms_pkg::SPEED_W-1:0]       max_speed_q;

	// controller state
	logic signed [pms_pkg::ERR_W-1:0] prev_err_q;
	logic signed [pms_pkg::SUM_W-1:0] error_sum_q;
	logic signed [pms_pkg::PWM_W-1:0] prev_pwm_q;

	// per-tick working registers
	logic signed [pms_pkg::ERR_W-1:0]  err_q;
	logic signed [pms_pkg::DERR_W-1:0] derr_q;
	logic signed [S_W-1:0]             s_q;
	logic                              neg_q;
	logic                              out_valid_q;
	pms_pkg::out_item_t                out_q;

	// combinational
	logic                              accept;
	logic signed [pms_pkg::ERR_W-1:0]  err_c;
	logic signed [pms_pkg::DERR_W-1:0] derr_c;
	logic signed [pms_pkg::SUM_W:0]    sum_c;
	logic signed [pms_pkg::SUM_W-1:0]  sum_sat;
	logic signed [pms_pkg::PID_W-1:0]  pid_c;
	logic signed [S_W-1:0]             pm_ext, s_sum, lim_ext, mag;
	logic                              neg_c;
	logic [DV_W-1:0]                   dividend;
	logic [pms_pkg::QX_W-1:0]          q_ext;
	logic [pms_pkg::PWM_W-2:0]         mag8;
	logic [pms_pkg::PWM_W-1:0]         pwm_pos;
	logic signed [pms_pkg::PWM_W-1:0]  pwm_next;
	logic                              out_load;
	logic                              start1, start2, start_div;

	// unit results
	logic                                busy_p, busy_i, busy_d, busy_pf, busy_mf, busy_pm;
	logic                                div_busy;
	logic signed [pms_pkg::P_ERR_W-1:0]  prod_p;
	logic signed [pms_pkg::P_SUM_W-1:0]  prod_i;
	logic signed [pms_pkg::P_DERR_W-1:0] prod_d;
	logic signed [S_W-1:0]               prod_pf;
	logic signed [LIM_W-1:0]             prod_mf;
	logic signed [pms_pkg::PM_W-1:0]     prod_pm;
	logic [FS_W-1:0]                     div_quot;

	assign accept    = sample.valid && sample.ready;
	assign start1    = (state_q == ST_LOAD1);
	assign start2    = (state_q == ST_ADD);
	assign start_div = (state_q == ST_SAT);
	assign out_load  = (state_q == ST_DIV) && !div_busy && (!out_valid_q || result.ready);

	// error, derivative difference and saturating integral
	always_comb begin
		err_c  = pms_pkg::ERR_W'(sample.data.target_speed)
			- pms_pkg::ERR_W'(sample.data.measured_speed);
		derr_c = pms_pkg::DERR_W'(err_c) - pms_pkg::DERR_W'(prev_err_q);
		sum_c  = (pms_pkg::SUM_W+1)'(error_sum_q) + (pms_pkg::SUM_W+1)'(err_c);
		if (sum_c[pms_pkg::SUM_W] != sum_c[pms_pkg::SUM_W-1]) begin
			sum_sat = sum_c[pms_pkg::SUM_W] ? pms_pkg::SUM_MIN : pms_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_c[pms_pkg::SUM_W-1:0];
		end
	end

	// Q8.8 PID sum of the three gain products
	assign pid_c = pms_pkg::PID_W'(prod_p) + pms_pkg::PID_W'(prod_d)
		+ pms_pkg::PID_W'(prod_i);

	// previous PWM in rpm (x256 x full scale) plus the correction; clamp limit
	assign pm_ext  = S_W'(prod_pm);
	assign s_sum   = prod_pf + (pm_ext <<< pms_pkg::FRAC_W);
	assign lim_ext = S_W'(prod_mf) <<< pms_pkg::FRAC_W;

	// clamp to +/- limit and split into sign and magnitude
	always_comb begin
		if (s_q > lim_ext) begin
			mag   = lim_ext;
			neg_c = 1'b0;
		end else if (s_q < -lim_ext) begin
			mag   = lim_ext;
			neg_c = 1'b1;
		end else if (s_q < 0) begin
			mag   = -s_q;
			neg_c = 1'b1;
		end else begin
			mag   = s_q;
			neg_c = 1'b0;
		end
	end

	assign dividend = mag[pms_pkg::FRAC_W +: DV_W];

	// quotient to signed PWM, saturated to the output range
	always_comb begin
		q_ext = pms_pkg::QX_W'(div_quot);
		if (max_speed_q == '0) begin
			mag8 = '0;
		end else if (q_ext > pms_pkg::QX_W'(pms_pkg::PWM_MAG_MAX)) begin
			mag8 = pms_pkg::PWM_MAG_MAX;
		end else begin
			mag8 = q_ext[pms_pkg::PWM_W-2:0];
		end
		pwm_pos  = {1'b0, mag8};
		pwm_next = neg_q ? signed'(pms_pkg::PWM_W'(0) - pwm_pos) : signed'(pwm_pos);
	end

	// sequencer
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					state_next = ST_LOAD1;
				end
			end
			ST_LOAD1: state_next = ST_MUL1;
			ST_MUL1: begin
				if (!(busy_p || busy_i || busy_d)) begin
					state_next = ST_ADD;
				end
			end
			ST_ADD: state_next = ST_MUL2;
			ST_MUL2: begin
				if (!(busy_pf || busy_mf || busy_pm)) begin
					state_next = ST_CLAMP;
				end
			end
			ST_CLAMP: state_next = ST_SAT;
			ST_SAT: state_next = ST_DIV;
			ST_DIV: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// control state, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_p_q    <= pms_pkg::GAIN_P_RST;
			gain_i_q    <= pms_pkg::GAIN_I_RST;
			gain_d_q    <= pms_pkg::GAIN_D_RST;
			max_speed_q <= pms_pkg::MAX_SPEED_RST;
			prev_err_q  <= '0;
			error_sum_q <= '0;
			prev_pwm_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg.valid) begin
				case (cfg.data.index)
					pms_pkg::REG_GAIN_P:    gain_p_q    <= cfg.data.value;
					pms_pkg::REG_GAIN_I:    gain_i_q    <= cfg.data.value;
					pms_pkg::REG_GAIN_D:    gain_d_q    <= cfg.data.value;
					pms_pkg::REG_MAX_SPEED: max_speed_q <= cfg.data.value;
					default: ;
				endcase
			end
			if (accept) begin
				prev_err_q  <= err_c;
				error_sum_q <= sum_sat;
			end
			if (out_load) begin
				prev_pwm_q  <= pwm_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= err_c;
			derr_q <= derr_c;
		end
		if (state_q == ST_CLAMP) begin
			s_q <= s_sum;
		end
		if (state_q == ST_SAT) begin
			neg_q <= neg_c;
		end
		if (out_load) begin
			out_q.pwm_out <= pwm_next;
		end
	end

	// first pass: the three gain products
	pms_serial_mul #(
		.A_W(pms_pkg::ERR_W), .B_W(pms_pkg::GAIN_W), .P_W(pms_pkg::P_ERR_W), .B_SIGNED(1'b1)
	) u_mul_p (
		.clk, .arst_n, .start(start1), .mcand(err_q), .mplier(gain_p_q),
		.busy(busy_p), .product(prod_p)
	);

	pms_serial_mul #(
		.A_W(pms_pkg::DERR_W), .B_W(pms_pkg::GAIN_W), .P_W(pms_pkg::P_DERR_W),
		.B_SIGNED(1'b1)
	) u_mul_d (
		.clk, .arst_n, .start(start1), .mcand(derr_q), .mplier(gain_d_q),
		.busy(busy_d), .product(prod_d)
	);

	pms_serial_mul #(
		.A_W(pms_pkg::SUM_W), .B_W(pms_pkg::GAIN_W), .P_W(pms_pkg::P_SUM_W), .B_SIGNED(1'b1)
	) u_mul_i (
		.clk, .arst_n, .start(start1), .mcand(error_sum_q), .mplier(gain_i_q),
		.busy(busy_i), .product(prod_i)
	);

	// second pass: scale the correction, the limit and the previous PWM
	pms_serial_mul #(
		.A_W(pms_pkg::PID_W), .B_W(FS_W), .P_W(S_W), .B_SIGNED(1'b0)
	) u_mul_pf (
		.clk, .arst_n, .start(start2), .mcand(pid_c), .mplier(FS_VAL),
		.busy(busy_pf), .product(prod_pf)
	);

	pms_serial_mul #(
		.A_W(pms_pkg::SPEED_W + 1), .B_W(FS_W), .P_W(LIM_W), .B_SIGNED(1'b0)
	) u_mul_mf (
		.clk, .arst_n, .start(start2), .mcand(signed'({1'b0, max_speed_q})),
		.mplier(FS_VAL), .busy(busy_mf), .product(prod_mf)
	);

	pms_serial_mul #(
		.A_W(pms_pkg::PWM_W), .B_W(pms_pkg::SPEED_W), .P_W(pms_pkg::PM_W), .B_SIGNED(1'b0)
	) u_mul_pm (
		.clk, .arst_n, .start(start2), .mcand(prev_pwm_q), .mplier(max_speed_q),
		.busy(busy_pm), .product(prod_pm)
	);

	// rescale to PWM: |s| / (256 * max_speed)
	pms_serial_div #(
		.Q_W(FS_W), .D_W(pms_pkg::SPEED_W)
	) u_div (
		.clk, .arst_n, .start(start_div), .dividend(dividend), .divisor(max_speed_q),
		.busy(div_busy), .quotient(div_quot)
	);

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

@@ hdl/pms_checker.sv @@
// ----------------------------------------------------------------------------
// pms_checker
// Port-level assertions for the PID motor speed PWM controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pms_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pms_pkg::PWM_W-1:0]    pwm_out
);

	localparam logic [pms_pkg::PWM_W-1:0] PWM_BAD = {1'b1, {(pms_pkg::PWM_W-1){1'b0}}};

	logic [1:0] pending_q;
	logic       in_txn, out_txn;

	assign in_txn  = in_valid && in_ready;
	assign out_txn = out_valid && out_ready;

	// ticks taken whose result has not yet been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_txn && !out_txn) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_txn && !in_txn) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(pwm_out), "result changed while stalled")
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_txn, !in_ready, "sample taken while a tick is in progress")
	`ASSERT_IMPLIES(a_pwm_range, clk, arst_n, out_valid, pwm_out != PWM_BAD, "pwm outside -255..255")
	`ASSERT_IMPLIES(a_no_extra, clk, arst_n, out_valid, pending_q != 2'd0, "result without a sample")

endmodule

bind pid_motor_speed_pwm pms_checker u_pms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.pwm_out   (result.data.pwm_out)
);

@@ verif/pid_motor_speed_pwm_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_speed_pwm_chk
// Watches the cfg, sample and result channels of the PID speed controller.
// It keeps its own copy of the gains, the integral, the last error and the
// last duty value. Each sample transaction steps that copy to predict a PWM
// duty. Each result transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_motor_speed_pwm_chk
	import pms_pkg::*;
#(
	parameter int FULL_SCALE = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_item_t cfg_data,
	input  logic      sample_valid,
	input  logic      sample_ready,
	input  in_item_t  sample_data,
	input  logic      result_valid,
	input  logic      result_ready,
	input  out_item_t result_data,
	output int        fail_count,
	output int        pending
);

	// register copies
	logic signed [GAIN_W-1:0] kp        = GAIN_P_RST;
	logic signed [GAIN_W-1:0] ki        = GAIN_I_RST;
	logic signed [GAIN_W-1:0] kd        = GAIN_D_RST;
	logic [SPEED_W-1:0]       speed_max = MAX_SPEED_RST;

	// controller state
	logic signed [ERR_W-1:0] last_err     = '0;
	logic signed [SUM_W-1:0] err_integral = '0;
	logic signed [PWM_W-1:0] last_duty    = '0;

	// duty values predicted and not yet seen on the result channel
	logic signed [PWM_W-1:0] duty_fifo[$];
	int                      depth      = 0;
	int                      mismatches = 0;

	assign fail_count = mismatches;
	assign pending    = depth;

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 25)
			$display("%0t ERROR %s", $time, what);
	endtask

	// One control tick: everything is kept exact in a numerator scaled by
	// 256*FULL_SCALE; the only rounding is the final division.
	function automatic logic signed [PWM_W-1:0] next_duty(input in_item_t it);
		longint e;
		longint acc;
		longint pid_q8;
		longint num;
		longint lim;
		longint scale;
		longint duty;
		e = longint'(it.target_speed) - longint'(it.measured_speed);

		// saturating integral
		acc = longint'(err_integral) + e;
		if (acc > longint'(SUM_MAX))
			acc = longint'(SUM_MAX);
		if (acc < longint'(SUM_MIN))
			acc = longint'(SUM_MIN);
		err_integral = acc[SUM_W-1:0];

		// PID correction in Q8.8 rpm
		pid_q8 = longint'(kp) * e
			+ longint'(kd) * (e - longint'(last_err))
			+ longint'(ki) * longint'(err_integral);
		last_err = e[ERR_W-1:0];

		// previous duty in rpm plus correction, clamped to +/- max speed
		num = longint'(last_duty) * longint'(speed_max) * 256 + pid_q8 * FULL_SCALE;
		lim = longint'(speed_max) * 256 * FULL_SCALE;
		if (num > lim)
			num = lim;
		if (num < -lim)
			num = -lim;

		// back to duty, truncating toward zero; empty range gives zero
		scale = longint'(speed_max) * 256;
		if (speed_max == '0)
			duty = 0;
		else
			duty = num / scale;
		if (duty > longint'(PWM_MAG_MAX))
			duty = longint'(PWM_MAG_MAX);
		if (duty < -longint'(PWM_MAG_MAX))
			duty = -longint'(PWM_MAG_MAX);
		last_duty = duty[PWM_W-1:0];
		return last_duty;
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [PWM_W-1:0] want;
		if (!arst_n) begin
			kp           = GAIN_P_RST;
			ki           = GAIN_I_RST;
			kd           = GAIN_D_RST;
			speed_max    = MAX_SPEED_RST;
			last_err     = '0;
			err_integral = '0;
			last_duty    = '0;
			duty_fifo.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_GAIN_P:    kp = cfg_data.value;
					REG_GAIN_I:    ki = cfg_data.value;
					REG_GAIN_D:    kd = cfg_data.value;
					REG_MAX_SPEED: speed_max = cfg_data.value;
					default: ;
				endcase
			end
			// result first, so a stray result cannot match a same-cycle sample
			if (result_valid && result_ready) begin
				if (duty_fifo.size() == 0) begin
					report($sformatf("pwm_out %0d with no sample outstanding",
						result_data.pwm_out));
				end else begin
					want = duty_fifo.pop_front();
					if (result_data.pwm_out !== want)
						report($sformatf("pwm_out %0d, predicted %0d",
							result_data.pwm_out, want));
				end
			end
			// step the controller copy
			if (sample_valid && sample_ready)
				duty_fifo.push_back(next_duty(sample_data));
		end
		depth = duty_fifo.size();
	end

endmodule

@@ verif/pid_motor_speed_pwm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_speed_pwm_tb
// Stimulus and verdict for the PID speed controller. A short directed run
// covers speed extremes, gain extremes and a zero max_speed; random phases
// follow with new gains between them, random gaps on both channels and one
// long result hold-off. The integral is then pushed hard in one direction
// with the largest error and backed off; a short random run closes it.
// Checking lives in pid_motor_speed_pwm_chk.
// ----------------------------------------------------------------------------
module pid_motor_speed_pwm_tb;
	import pms_pkg::*;

	localparam int PWM_FS          = 255;
	localparam int HOLD_CYCLES     = 400;
	localparam int IDLE_LIMIT      = 4000;
	localparam int SETTLE_CYCLES   = 60;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int RAMP_ITEMS      = 40;

	logic clk = 1'b0;
	logic arst_n;

	pms_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
	pms_stream_if #(.payload_t(in_item_t))  sample_if ();
	pms_stream_if #(.payload_t(out_item_t)) result_if ();

	bit src_gaps    = 1'b0;
	bit sink_gaps   = 1'b0;
	int hold_req    = 0;
	int hold_ack    = 0;
	int idle_cycles = 0;
	int fail_count;
	int pending;

	pid_motor_speed_pwm #(
		.PWM_FULL_SCALE(PWM_FS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.sample (sample_if),
		.result (result_if)
	);

	pid_motor_speed_pwm_chk #(
		.FULL_SCALE(PWM_FS)
	) u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_if.valid),
		.cfg_ready    (cfg_if.ready),
		.cfg_data     (cfg_if.data),
		.sample_valid (sample_if.valid),
		.sample_ready (sample_if.ready),
		.sample_data  (sample_if.data),
		.result_valid (result_if.valid),
		.result_ready (result_if.ready),
		.result_data  (result_if.data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(40, 120);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return '0;
			3, 4, 5: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return raw[15:0];
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3, 4, 5, 6, 7, 8: return 16'($urandom_range(50, 3000));
			default: return raw[15:0];
		endcase
	endfunction

	function automatic in_item_t mk_speeds(input int t, input int m);
		in_item_t it;
		it.target_speed   = 16'(t);
		it.measured_speed = 16'(m);
		return it;
	endfunction

	// random speeds: some over the full range, most near each other
	function automatic in_item_t rand_tick(input int span);
		logic [31:0] raw;
		int          t;
		int          m;
		raw = $urandom;
		if ($urandom_range(0, 3) == 0)
			return mk_speeds(int'($signed(raw[31:16])), int'($signed(raw[15:0])));
		t = int'($urandom_range(0, 2 * span)) - span;
		m = t + int'($urandom_range(0, span / 2)) - span / 4;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		if (m > 32767)
			m = 32767;
		if (m < -32768)
			m = -32768;
		return mk_speeds(t, m);
	endfunction

	// one sample transaction, after an optional gap
	task automatic send_tick(input in_item_t it);
		int gap;
		gap = src_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_if.valid <= 1'b1;
		sample_if.data  <= it;
		do @(posedge clk); while (!sample_if.ready);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{index: idx, value: val};
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// all four registers, only with the block idle
	task automatic set_config(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
			input logic [GAIN_W-1:0] gd, input logic [SPEED_W-1:0] ms);
		wait_drained();
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_MAX_SPEED, ms);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls plus the long hold-off on request
	initial begin : sink_side
		int stall_left;
		stall_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_req != hold_ack) begin
				stall_left = HOLD_CYCLES;
				hold_ack++;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			result_if.ready <= (stall_left == 0);
		end
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cfg_if.valid && cfg_if.ready) || (sample_if.valid && sample_if.ready)
					|| (result_if.valid && result_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [SPEED_W-1:0] top_speed;
		int                 span;
		arst_n = 1'b0;
		cfg_if.valid    <= 1'b0;
		cfg_if.data     <= '{index: REG_GAIN_P, value: '0};
		sample_if.valid <= 1'b0;
		sample_if.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: speed extremes and bit patterns
		send_tick(mk_speeds(0, 0));
		send_tick(mk_speeds(32767, -32768));
		send_tick(mk_speeds(-32768, 32767));
		send_tick(mk_speeds(32767, 32767));
		send_tick(mk_speeds(-32768, -32768));
		send_tick(mk_speeds(50, 0));
		send_tick(mk_speeds(0, 50));
		send_tick(mk_speeds(-1, 0));
		send_tick(mk_speeds(int'(16'sh5555), int'(16'shAAAA)));
		send_tick(mk_speeds(int'(16'shAAAA), int'(16'sh5555)));

		// largest positive gains, integral gain at its negative end, full speed
		set_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_tick(mk_speeds(1000, -1000));
		send_tick(mk_speeds(-32768, 32767));
		send_tick(mk_speeds(0, 0));
		send_tick(mk_speeds(32767, -32768));

		// mirrored gains, smallest nonzero max speed
		set_config(16'h8000, 16'h7FFF, 16'h8000, 16'd1);
		send_tick(mk_speeds(1, 0));
		send_tick(mk_speeds(-1, 0));
		send_tick(mk_speeds(0, 0));
		send_tick(mk_speeds(300, 200));

		// zero max speed: the clamp range is empty, duty must be zero
		set_config(16'd256, 16'd16, 16'hFF00, '0);
		send_tick(mk_speeds(1000, 0));
		send_tick(mk_speeds(-1000, 0));
		send_tick(mk_speeds(0, 0));

		// random phases, new registers between them
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			top_speed = pick_speed();
			set_config(pick_gain(), pick_gain(), pick_gain(), top_speed);
			span = (top_speed == '0) ? 2000 : int'(top_speed);
			if (span > 16000)
				span = 16000;
			if (span < 8)
				span = 8;
			src_gaps  = (p != 2);
			sink_gaps = (p != 2);
			// long result hold-off while samples keep coming
			if (p == 4) begin
				src_gaps = 1'b0;
				hold_req++;
			end
			repeat (ITEMS_PER_PHASE) send_tick(rand_tick(span));
		end

		// ramp the integral with the largest error, then back off it
		set_config('0, 16'd1, '0, 16'hFFFF);
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		repeat (RAMP_ITEMS) send_tick(mk_speeds(32767, -32768));
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		repeat (8) send_tick(mk_speeds(-32768, 32767));
		set_config(pick_gain(), pick_gain(), pick_gain(), pick_speed());
		repeat (40) send_tick(rand_tick(4000));

		wait_drained();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pms_pkg.sv
hdl/pms_stream_if.sv
hdl/pms_serial_mul.sv
hdl/pms_serial_div.sv
hdl/pid_motor_speed_pwm.sv
hdl/pms_checker.sv
verif/pid_motor_speed_pwm_chk.sv
verif/pid_motor_speed_pwm_tb.sv
